/* design/xsc_pkg.sv */
// Shared types and constants for the load file segment chunker.
`timescale 1ns / 1ps

package xsc_pkg;

  // Fixed payload widths of the two channels
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 8;
  localparam int OFFSET_W = 24;
  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 13;

  // Marker that may precede a segment start address
  localparam logic [ADDR_W-1:0] SEG_MARKER = 16'hFFFF;

  // Header length in bytes
  localparam logic [1:0] HEADER_LEN = 2'd2;

  // Parser phases
  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_START_LO = 6'b000010,
    PH_START_HI = 6'b000100,
    PH_END_LO   = 6'b001000,
    PH_END_HI   = 6'b010000,
    PH_DATA     = 6'b100000
  } phase_t;

  // One registered input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] file_byte;
    logic              image_start;
  } item_t;

  // One chunk record
  typedef struct packed {
    logic [INDEX_W-1:0]  record_index;
    logic [OFFSET_W-1:0] file_offset;
    logic [ADDR_W-1:0]   load_address;
    logic [SIZE_W-1:0]   load_size;
    logic                table_overflow;
  } rec_t;

  // Parser result for one step
  typedef struct packed {
    logic emit;
    rec_t rec;
  } step_res_t;

endpackage

/* design/xsc_in_if.sv */
// Input byte channel: valid, ready and one file byte with its image flag.
`timescale 1ns / 1ps

interface xsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [xsc_pkg::BYTE_W-1:0] file_byte;
  logic                      image_start;

  modport source (output valid, output file_byte, output image_start, input ready);
  modport sink   (input valid, input file_byte, input image_start, output ready);
endinterface

/* design/xsc_out_if.sv */
// Output record channel: valid, ready and one chunk record.
`timescale 1ns / 1ps

interface xsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [xsc_pkg::INDEX_W-1:0]  record_index;
  logic [xsc_pkg::OFFSET_W-1:0] file_offset;
  logic [xsc_pkg::ADDR_W-1:0]   load_address;
  logic [xsc_pkg::SIZE_W-1:0]   load_size;
  logic                        table_overflow;

  modport source (output valid, output record_index, output file_offset,
                  output load_address, output load_size, output table_overflow,
                  input ready);
  modport sink   (input valid, input record_index, input file_offset,
                  input load_address, input load_size, input table_overflow,
                  output ready);
endinterface

/* design/xsc_parser.sv */
// Segment parser state and the single-step update for one file byte.
`timescale 1ns / 1ps

module xsc_parser #(
  parameter int CHUNK_LIMIT = 256,
  parameter int MAX_RECORDS = 256,
  parameter int OFFSET_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  xsc_pkg::item_t     item,
  output xsc_pkg::step_res_t res
);
  import xsc_pkg::*;

  localparam int FILL_W = $clog2(CHUNK_LIMIT + 1);
  localparam int RC_W   = $clog2(MAX_RECORDS + 1);
  localparam logic [FILL_W-1:0]   FILL_LIMIT = FILL_W'(CHUNK_LIMIT);
  localparam logic [ADDR_W-1:0]   ADDR_STEP  = ADDR_W'(CHUNK_LIMIT);
  localparam logic [RC_W-1:0]     RC_LIMIT   = RC_W'(MAX_RECORDS);

  // State registers
  phase_t                 phase;
  logic [1:0]             hdr_cnt;
  logic                   marker_skipped;
  logic [ADDR_W-1:0]      seg_start;
  logic [BYTE_W-1:0]      end_low;
  logic [ADDR_W-1:0]      bytes_left;
  logic [FILL_W-1:0]      chunk_fill;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic [RC_W-1:0]        rec_count;

  phase_t                 phase_next;
  logic [1:0]             hdr_cnt_next;
  logic                   marker_skipped_next;
  logic [ADDR_W-1:0]      seg_start_next;
  logic [BYTE_W-1:0]      end_low_next;
  logic [ADDR_W-1:0]      bytes_left_next;
  logic [FILL_W-1:0]      chunk_fill_next;
  logic [OFFSET_BITS-1:0] byte_pos_next;
  logic [RC_W-1:0]        rec_count_next;

  // Values seen by this byte: a new image starts from the reset state
  phase_t                 cur_phase;
  logic [1:0]             cur_hdr_cnt;
  logic                   cur_marker;
  logic [ADDR_W-1:0]      cur_seg;
  logic [ADDR_W-1:0]      cur_left;
  logic [FILL_W-1:0]      cur_fill;
  logic [OFFSET_BITS-1:0] cur_pos;
  logic [RC_W-1:0]        cur_rc;

  logic [ADDR_W-1:0]      start_word;
  logic [ADDR_W-1:0]      end_word;
  logic [ADDR_W-1:0]      seg_size;
  logic [ADDR_W-1:0]      emit_len_src;
  logic [ADDR_W-1:0]      emit_addr;
  logic [OFFSET_BITS-1:0] emit_pos;
  logic                   do_emit;
  logic                   ovf;

  always_comb begin
    cur_phase   = item.image_start ? PH_HEADER : phase;
    cur_hdr_cnt = item.image_start ? 2'd0 : hdr_cnt;
    cur_marker  = item.image_start ? 1'b0 : marker_skipped;
    cur_seg     = item.image_start ? '0 : seg_start;
    cur_left    = item.image_start ? '0 : bytes_left;
    cur_fill    = item.image_start ? '0 : chunk_fill;
    cur_pos     = item.image_start ? '0 : byte_pos;
    cur_rc      = item.image_start ? '0 : rec_count;
  end

  assign start_word = {item.file_byte, cur_seg[BYTE_W-1:0]};
  assign end_word   = {item.file_byte, item.image_start ? 8'd0 : end_low};
  assign seg_size   = end_word - cur_seg + 16'd1;

  // Advance the parse by one byte
  always_comb begin
    phase_next          = cur_phase;
    hdr_cnt_next        = cur_hdr_cnt;
    marker_skipped_next = cur_marker;
    seg_start_next      = cur_seg;
    end_low_next        = item.image_start ? 8'd0 : end_low;
    bytes_left_next     = cur_left;
    chunk_fill_next     = cur_fill;
    byte_pos_next       = cur_pos + 1'b1;
    do_emit             = 1'b0;
    emit_len_src        = seg_size;
    emit_addr           = cur_seg;
    emit_pos            = cur_pos + 1'b1;

    unique case (cur_phase)
      PH_HEADER: begin
        hdr_cnt_next = cur_hdr_cnt + 2'd1;
        if (hdr_cnt_next >= HEADER_LEN) begin
          phase_next = PH_START_LO;
        end
      end
      PH_START_HI: begin
        seg_start_next = start_word;
        if (start_word == SEG_MARKER && !cur_marker) begin
          marker_skipped_next = 1'b1;
          phase_next          = PH_START_LO;
        end else begin
          phase_next = PH_END_LO;
        end
      end
      PH_END_LO: begin
        end_low_next = item.file_byte;
        phase_next   = PH_END_HI;
      end
      PH_END_HI: begin
        do_emit             = 1'b1;
        marker_skipped_next = 1'b0;
        if (seg_size == '0) begin
          phase_next = PH_START_LO;
        end else begin
          bytes_left_next = seg_size;
          chunk_fill_next = '0;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        chunk_fill_next = cur_fill + 1'b1;
        if (cur_fill >= FILL_LIMIT) begin
          seg_start_next  = cur_seg + ADDR_STEP;
          chunk_fill_next = FILL_W'(1);
          do_emit         = 1'b1;
          emit_len_src    = cur_left;
          emit_addr       = cur_seg + ADDR_STEP;
          emit_pos        = cur_pos;
        end
        bytes_left_next = cur_left - 16'd1;
        if (bytes_left_next == '0) begin
          marker_skipped_next = 1'b0;
          phase_next          = PH_START_LO;
        end
      end
      default: begin
        seg_start_next = {8'd0, item.file_byte};
        phase_next     = PH_START_HI;
      end
    endcase
  end

  // Build the record and count it unless the table is full
  always_comb begin
    ovf                    = cur_rc >= RC_LIMIT;
    res.emit               = do_emit;
    res.rec.record_index   = ovf ? '0 : INDEX_W'(cur_rc);
    res.rec.file_offset    = OFFSET_W'(emit_pos);
    res.rec.load_address   = emit_addr;
    res.rec.load_size      = (emit_len_src < ADDR_STEP) ? SIZE_W'(emit_len_src)
                                                        : SIZE_W'(CHUNK_LIMIT);
    res.rec.table_overflow = ovf;
    rec_count_next         = (do_emit && !ovf) ? cur_rc + 1'b1 : cur_rc;
  end

  // Hold state until a byte is stepped
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      hdr_cnt        <= '0;
      marker_skipped <= 1'b0;
      seg_start      <= '0;
      end_low        <= '0;
      bytes_left     <= '0;
      chunk_fill     <= '0;
      byte_pos       <= '0;
      rec_count      <= '0;
    end else if (step) begin
      phase          <= phase_next;
      hdr_cnt        <= hdr_cnt_next;
      marker_skipped <= marker_skipped_next;
      seg_start      <= seg_start_next;
      end_low        <= end_low_next;
      bytes_left     <= bytes_left_next;
      chunk_fill     <= chunk_fill_next;
      byte_pos       <= byte_pos_next;
      rec_count      <= rec_count_next;
    end
  end

endmodule

/* design/xex_segment_chunker.sv */
// Top level: input register, segment parser and output record register.
// Path: an accepted byte is held in the input register and its record in the output register.
// Throughput: one byte per cycle unless the output stalls; the parser step is combinational.
// A stalled output register holds its record while one more byte waits in the input register.
// Reset: synchronous rst empties both registers and returns the parser to the header phase.
`timescale 1ns / 1ps

module xex_segment_chunker #(
  parameter int CHUNK_LIMIT = 256,
  parameter int MAX_RECORDS = 256,
  parameter int OFFSET_BITS = 24
) (
  input logic      clk,
  input logic      rst,
  xsc_in_if.sink   stream,
  xsc_out_if.source records
);
  import xsc_pkg::*;

  logic      in_valid_q;
  item_t     in_item_q;
  logic      out_valid;
  rec_t      out_rec;
  logic      advance;
  logic      step;
  step_res_t res;

  assign advance      = !out_valid || records.ready;
  assign step         = in_valid_q && advance;
  assign stream.ready = !in_valid_q || advance;

  // Capture an input transaction, drop it once stepped
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_item_q.file_byte   <= stream.file_byte;
      in_item_q.image_start <= stream.image_start;
    end
  end

  xsc_parser #(
    .CHUNK_LIMIT(CHUNK_LIMIT),
    .MAX_RECORDS(MAX_RECORDS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk (clk),
    .rst (rst),
    .step(step),
    .item(in_item_q),
    .res (res)
  );

  // Load a record when the output is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_rec <= res.rec;
    end
  end

  assign records.valid          = out_valid;
  assign records.record_index   = out_rec.record_index;
  assign records.file_offset    = out_rec.file_offset;
  assign records.load_address   = out_rec.load_address;
  assign records.load_size      = out_rec.load_size;
  assign records.table_overflow = out_rec.table_overflow;

  // A waiting byte stays put while the output stalls
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q))
    else $error("input register changed while stalled");

  // Dropped records carry index zero
  a_ovf_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rec.table_overflow |-> out_rec.record_index == '0)
    else $error("overflow record with nonzero index");

  // Chunk size never exceeds the limit
  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rec.load_size <= SIZE_W'(CHUNK_LIMIT))
    else $error("chunk size above limit");

endmodule
